/* sv/scale_note_quantiser_assert.svh */
`ifndef SCALE_NOTE_QUANTISER_ASSERT_SVH
`define SCALE_NOTE_QUANTISER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define SNQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define SNQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/snq_pkg.sv */
package snq_pkg;

  localparam int MAX_SCALE_NOTES = 8;
  localparam int LIST_DEPTH      = 256;

  localparam int NOTE_W = 8;
  localparam int IN_W   = 16;
  localparam int ROOT_W = 4;
  localparam int OCT_W  = 5;
  localparam int CNT_W  = 4;
  localparam int OFFS_W = 64;
  localparam int K_W    = (MAX_SCALE_NOTES > 1) ? $clog2(MAX_SCALE_NOTES) : 1;
  localparam int IDX_W  = $clog2(LIST_DEPTH);
  localparam int CFG_IDX_W = 3;

  localparam logic [NOTE_W-1:0] OCTAVE_SEMIS = NOTE_W'(12);
  localparam logic [OCT_W-1:0]  OCTAVE_LIMIT = OCT_W'(20);
  localparam logic [CNT_W-1:0]  COUNT_LIMIT  = CNT_W'(MAX_SCALE_NOTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT    = 3'd0,
    REG_FIRST   = 3'd1,
    REG_LAST    = 3'd2,
    REG_COUNT   = 3'd3,
    REG_OFFSETS = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [OCT_W-1:0]  first;
    logic [OCT_W-1:0]  last;
    logic [CNT_W-1:0]  count;
    logic [OFFS_W-1:0] offsets;
  } cfg_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              last;
    logic              empty;
  } gen_t;

endpackage

/* sv/snq_note_gen.sv */
// Walks the allowed-note list one entry per step.
module snq_note_gen import snq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic start_i,
  input  logic step_i,
  output gen_t gen_o
);

  logic [OCT_W-1:0]  lo, hi;
  logic [CNT_W-1:0]  cnt;
  logic [OCT_W+4:0]  lo_x12;
  logic [NOTE_W-1:0] base_start;
  logic [NOTE_W-1:0] offs [MAX_SCALE_NOTES];
  logic              k_wrap;

  logic [OCT_W-1:0]  oct_q, oct_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [NOTE_W-1:0] base_q, base_d;

  always_comb begin
    lo  = (cfg_i.first > OCTAVE_LIMIT) ? OCTAVE_LIMIT : cfg_i.first;
    hi  = (cfg_i.last > OCTAVE_LIMIT) ? OCTAVE_LIMIT : cfg_i.last;
    cnt = (cfg_i.count > COUNT_LIMIT) ? COUNT_LIMIT : cfg_i.count;
    // Twelve times the octave as two shifted copies.
    lo_x12 = {lo, 3'b000} + {2'b00, lo, 2'b00};
    base_start = NOTE_W'(lo_x12) + NOTE_W'(cfg_i.root);
    for (int i = 0; i < MAX_SCALE_NOTES; i++) begin
      offs[i] = cfg_i.offsets[NOTE_W*i +: NOTE_W];
    end
    k_wrap = (CNT_W'(k_q) + CNT_W'(1)) == cnt;
  end

  always_comb begin
    oct_d  = oct_q;
    k_d    = k_q;
    idx_d  = idx_q;
    base_d = base_q;
    if (start_i) begin
      oct_d  = lo;
      k_d    = '0;
      idx_d  = '0;
      base_d = base_start;
    end else if (step_i) begin
      idx_d = idx_q + IDX_W'(1);
      if (k_wrap) begin
        k_d    = '0;
        oct_d  = oct_q + OCT_W'(1);
        base_d = base_q + OCTAVE_SEMIS;
      end else begin
        k_d = k_q + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q  <= '0;
      k_q    <= '0;
      idx_q  <= '0;
      base_q <= '0;
    end else begin
      oct_q  <= oct_d;
      k_q    <= k_d;
      idx_q  <= idx_d;
      base_q <= base_d;
    end
  end

  always_comb begin
    gen_o.note  = base_q + offs[k_q];
    gen_o.last  = ((oct_q == hi) && k_wrap) || (idx_q == IDX_W'(LIST_DEPTH - 1));
    gen_o.empty = (lo > hi) || (cnt == '0);
  end

endmodule

/* sv/snq_pick.sv */
// Chooses the nearer of the bracketing notes, or the upper one when first_i is set; a tie goes to the lower one.
module snq_pick import snq_pkg::*; (
  input  logic [NOTE_W-1:0] note_i,
  input  logic [NOTE_W-1:0] above_i,
  input  logic [NOTE_W-1:0] below_i,
  input  logic              first_i,
  output logic [NOTE_W-1:0] result_o
);

  logic [NOTE_W-1:0] d_above, d_below;

  always_comb begin
    d_above = above_i - note_i;
    d_below = note_i - below_i;
    if (first_i || (d_above < d_below)) begin
      result_o = above_i;
    end else begin
      result_o = below_i;
    end
  end

endmodule

/* sv/scale_note_quantiser.sv */
// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+-------------------------------
// in       | input     | in_valid_i/in_stall_o  | incoming_note_i
// out      | output    | out_valid_o/out_stall_i| quantised_note_o, scale_empty_o
// cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_wdata_i
//
// A word is accepted, then the list is examined one entry per cycle (up to
// 21 octaves times 8 offsets, 168 entries), and the result is loaded into the
// output register once it is free; an empty list skips the scan.
// Reset is asynchronous and active low; it clears the configuration and the
// control registers, and the datapath registers are loaded before they are read.
// in_stall_o is high while a word is in work, including while its result waits.
`include "scale_note_quantiser_assert.svh"

module scale_note_quantiser import snq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [IN_W-1:0]      incoming_note_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [NOTE_W-1:0]    quantised_note_o,
  output logic                 scale_empty_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [OFFS_W-1:0]    cfg_wdata_i
);

  cfg_t              cfg_q;
  state_e            state_q, state_d;
  gen_t              gen;
  logic              gen_start, gen_step;
  logic              accept, hit;
  logic [IN_W-1:0]   note_q;
  logic [NOTE_W-1:0] prev_q;
  logic              have_prev_q;
  logic [NOTE_W-1:0] pick;
  logic [NOTE_W-1:0] res_q, res_d;
  logic              res_empty_q, res_empty_d;
  logic              load_res, load_out;
  logic              out_valid_q;
  logic [NOTE_W-1:0] out_note_q;
  logic              out_empty_q;

  // The configuration port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ROOT:    cfg_q.root    <= cfg_wdata_i[ROOT_W-1:0];
        REG_FIRST:   cfg_q.first   <= cfg_wdata_i[OCT_W-1:0];
        REG_LAST:    cfg_q.last    <= cfg_wdata_i[OCT_W-1:0];
        REG_COUNT:   cfg_q.count   <= cfg_wdata_i[CNT_W-1:0];
        REG_OFFSETS: cfg_q.offsets <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  snq_note_gen u_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .start_i (gen_start),
    .step_i  (gen_step),
    .gen_o   (gen)
  );

  // On a hit the input is at most the entry, so its low byte is the whole note.
  snq_pick u_pick (
    .note_i   (note_q[NOTE_W-1:0]),
    .above_i  (gen.note),
    .below_i  (prev_q),
    .first_i  (!have_prev_q),
    .result_o (pick)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign hit        = {{(IN_W-NOTE_W){1'b0}}, gen.note} >= note_q;

  // The sequencer scans the list in order and stops at the first entry at or
  // above the input, or at the last entry when none qualifies; an empty list is not scanned.
  always_comb begin
    state_d     = state_q;
    gen_start   = 1'b0;
    gen_step    = 1'b0;
    load_res    = 1'b0;
    load_out    = 1'b0;
    res_d       = gen.note;
    res_empty_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          gen_start = 1'b1;
          if (gen.empty) begin
            res_d       = '0;
            res_empty_d = 1'b1;
            load_res    = 1'b1;
            state_d     = ST_FIN;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_d    = pick;
          load_res = 1'b1;
          state_d  = ST_FIN;
        end else if (gen.last) begin
          load_res = 1'b1;
          state_d  = ST_FIN;
        end else begin
          gen_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (gen_start) begin
        have_prev_q <= 1'b0;
      end else if (gen_step) begin
        have_prev_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      note_q <= incoming_note_i;
    end
    if (gen_step) begin
      prev_q <= gen.note;
    end
    if (load_res) begin
      res_q       <= res_d;
      res_empty_q <= res_empty_d;
    end
    if (load_out) begin
      out_note_q  <= res_q;
      out_empty_q <= res_empty_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quantised_note_o = out_note_q;
  assign scale_empty_o    = out_empty_q;

  `SNQ_ASSERT_NXT(a_hit_ends_scan, (state_q == ST_SCAN) && hit, state_q == ST_FIN,
                  "scan did not stop on a matching entry")
  `SNQ_ASSERT_NXT(a_empty_short, accept && gen.empty, (state_q == ST_FIN) && res_empty_q,
                  "empty scale did not go straight to the result")
  `SNQ_ASSERT_IMP(a_empty_zero, out_valid_o && scale_empty_o, quantised_note_o == '0,
                  "empty scale result carries a nonzero note")

endmodule

/* test/tb_scale_note_quantiser.sv */
`timescale 1ns / 100ps

// Testbench for scale_note_quantiser.
//
// The block snaps a 16-bit note number to the nearest note of a scale
// that is set up through five configuration registers. Every input word
// yields exactly one result word, so a plain FIFO of predicted results is
// enough. It is filled when an input word is accepted and drained when a
// result word is accepted.
//
// The bench keeps its own copy of the scale registers. The predictor
// rebuilds the list of allowed notes from that copy for every word. It then
// applies the nearest-note rule: a tie goes to the lower note, an input above
// every entry takes the last entry, and an empty list raises the flag.
//
// Registers are only rewritten while the block is idle. That is after reset,
// or after every predicted result has come back and a few more cycles have
// passed.
module tb_scale_note_quantiser;
  import snq_pkg::*;

  // The slowest legal run takes about 2000 words, each with a full-length
  // search plus the longest output stall and the longest input gap. This
  // limit leaves several times that.
  localparam int CYCLE_LIMIT  = 2_000_000;
  // After the last result, allow for one more full-length search.
  localparam int DRAIN_CYCLES = 180;
  localparam int SETTLE_CYCLES = 4;
  localparam int BURST_MAX    = 18;

  // Indexes past the last register. Writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // Packed offset tables used by the directed tests.
  localparam logic [OFFS_W-1:0] MAJOR_STEPS = 64'h000B_0907_0504_0200;
  localparam logic [OFFS_W-1:0] WRAP_STEPS  = 64'hFFF0_8040_2010_0100;
  localparam logic [OFFS_W-1:0] WIDE_STEPS  = 64'h0000_0000_0000_0A00;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              empty;
  } snap_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [IN_W-1:0]      incoming_note_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [NOTE_W-1:0]    quantised_note_o;
  logic                 scale_empty_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [OFFS_W-1:0]    cfg_wdata_i     = '0;

  // This is the bench's own view of the scale registers, which all reset to zero.
  logic [ROOT_W-1:0] scale_root      = '0;
  logic [OCT_W-1:0]  scale_first_oct = '0;
  logic [OCT_W-1:0]  scale_last_oct  = '0;
  logic [CNT_W-1:0]  scale_len       = '0;
  logic [OFFS_W-1:0] scale_steps     = '0;

  snap_t pending_snaps[$];
  int    mismatch_count = 0;
  int    cycle_count    = 0;
  int    stall_left     = 0;

  // Idle bursts on both channels. idle_pct is the chance, in percent, that a
  // burst starts at a given word or cycle. A setting of 0 gives a stretch with
  // no idling.
  bit idling   = 1'b1;
  int idle_pct = 30;

  always #5 clk_i = ~clk_i;

  scale_note_quantiser dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .incoming_note_i,
    .out_valid_o,
    .out_stall_i,
    .quantised_note_o,
    .scale_empty_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_wdata_i
  );

  // Build the allowed-note list from the bench's register copy, then pick the
  // nearest entry to the note. The list is walked in build order. Notes wrap
  // to 8 bits, so the list need not ascend.
  function automatic snap_t snap_to_scale(input logic [IN_W-1:0] note);
    logic [NOTE_W-1:0] entries [LIST_DEPTH];
    int oct_lo;
    int oct_hi;
    int steps_used;
    int n;
    int hit;
    int d_up;
    int d_down;
    snap_t snap;
    oct_lo = (scale_first_oct > OCTAVE_LIMIT) ? int'(OCTAVE_LIMIT) : int'(scale_first_oct);
    oct_hi = (scale_last_oct > OCTAVE_LIMIT) ? int'(OCTAVE_LIMIT) : int'(scale_last_oct);
    steps_used = (scale_len > MAX_SCALE_NOTES) ? MAX_SCALE_NOTES : int'(scale_len);
    n = 0;
    for (int oct = oct_lo; oct <= oct_hi; oct++) begin
      for (int k = 0; k < steps_used; k++) begin
        if (n < LIST_DEPTH) begin
          entries[n] = NOTE_W'(int'(scale_root) + int'(OCTAVE_SEMIS) * oct
                               + int'(scale_steps[8*k +: 8]));
          n++;
        end
      end
    end
    snap.note  = '0;
    snap.empty = (n == 0);
    if (n == 0) return snap;
    hit = 0;
    while (hit < n && entries[hit] < note) hit++;
    if (hit == n) begin
      snap.note = entries[n-1];
    end else if (hit == 0) begin
      snap.note = entries[0];
    end else begin
      d_up   = int'(entries[hit]) - int'(note);
      d_down = int'(note) - int'(entries[hit-1]);
      snap.note = (d_up < d_down) ? entries[hit] : entries[hit-1];
    end
    return snap;
  endfunction

  // Offer one configuration word and hold it until the block takes it. Valid
  // is left high so that back-to-back writes need no extra cycle. The caller
  // lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFFS_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ROOT:    scale_root      = value[ROOT_W-1:0];
      REG_FIRST:   scale_first_oct = value[OCT_W-1:0];
      REG_LAST:    scale_last_oct  = value[OCT_W-1:0];
      REG_COUNT:   scale_len       = value[CNT_W-1:0];
      REG_OFFSETS: scale_steps     = value;
      default: ;
    endcase
  endtask

  task automatic program_scale(input logic [ROOT_W-1:0] root, input logic [OCT_W-1:0] first_oct,
                               input logic [OCT_W-1:0] last_oct, input logic [CNT_W-1:0] len,
                               input logic [OFFS_W-1:0] steps);
    write_reg(REG_ROOT, OFFS_W'(root));
    write_reg(REG_FIRST, OFFS_W'(first_oct));
    write_reg(REG_LAST, OFFS_W'(last_oct));
    write_reg(REG_COUNT, OFFS_W'(len));
    write_reg(REG_OFFSETS, steps);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Present one note and wait until it is accepted. The prediction is made
  // at acceptance, and the registers cannot change while words are in flight.
  // A random gap may come first, with valid low for the whole burst.
  task automatic send_note(input logic [IN_W-1:0] note);
    if (idling && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, BURST_MAX)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    incoming_note_i <= note;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_snaps.insert(pending_snaps.size(), snap_to_scale(note));
  endtask

  // Stop offering notes and wait until every predicted result is back. The
  // block is idle after that, so the registers can be rewritten.
  task automatic finish_batch();
    in_valid_i <= 1'b0;
    while (pending_snaps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // After reset the octave range is 0..0 but the count is zero, so the list
  // is empty. Writes to unused indexes must leave it that way.
  task automatic test_empty_after_reset();
    send_note('0);
    send_note('1);
    finish_batch();
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, '1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_note(IN_W'(60));
    finish_batch();
  endtask

  // This is C major over octaves 0 to 10, so the list runs from 0 to 131. The
  // off-scale notes in the first octave sit halfway between two scale notes and
  // must go down. Inputs past 131, including those that need all 16 bits,
  // take the top entry.
  task automatic test_major_scale();
    program_scale(4'd0, 5'd0, 5'd10, 4'd7, MAJOR_STEPS);
    send_note(IN_W'(0));
    send_note(IN_W'(1));
    send_note(IN_W'(3));
    send_note(IN_W'(6));
    send_note(IN_W'(8));
    send_note(IN_W'(10));
    send_note(IN_W'(12));
    send_note(IN_W'(131));
    send_note(IN_W'(132));
    send_note(IN_W'(255));
    send_note(IN_W'(256));
    send_note('1);
    finish_batch();
  endtask

  // The root is above 11, the octaves are far above 20 and must saturate,
  // and the count is above the maximum and must clip to 8. The offsets push
  // most notes past 255, so the list wraps and does not ascend.
  task automatic test_saturation_and_wrap();
    program_scale(4'd15, 5'd31, 5'd31, 4'd15, WRAP_STEPS);
    send_note(IN_W'(0));
    send_note(IN_W'(128));
    send_note(IN_W'(256));
    send_note('1);
    finish_batch();
  endtask

  // These are empty lists from a reversed octave range and from a zero
  // count, then a two-note list with a wide gap. In that list the nearest
  // note wins clearly on both sides, and the midpoint ties downward.
  task automatic test_degenerate_lists();
    program_scale(4'd0, 5'd5, 5'd4, 4'd3, MAJOR_STEPS);
    send_note(IN_W'(70));
    finish_batch();
    program_scale(4'd0, 5'd0, 5'd20, 4'd0, '1);
    send_note(IN_W'(70));
    finish_batch();
    program_scale(4'd0, 5'd0, 5'd0, 4'd2, WIDE_STEPS);
    send_note(IN_W'(3));
    send_note(IN_W'(7));
    send_note(IN_W'(5));
    finish_batch();
  endtask

  // Each phase draws a fresh scale. Most are well formed: a short octave
  // span and ascending offsets 1 to 3 semitones apart. The rest use
  // reversed or saturating octaves, odd counts and raw 64-bit offset tables.
  // Notes mostly fall in the 8-bit range where the list lives. Some use the
  // full 16 bits.
  task automatic test_random_scales(input int phases, input int words_per_phase,
                                    input bit with_idling);
    logic [ROOT_W-1:0] root;
    logic [OCT_W-1:0]  lo;
    logic [OCT_W-1:0]  hi;
    logic [CNT_W-1:0]  len;
    logic [OFFS_W-1:0] steps;
    int acc;
    int roll;
    for (int p = 0; p < phases; p++) begin
      root = ROOT_W'($urandom_range(0, 15));
      lo   = ($urandom_range(0, 9) < 8) ? OCT_W'($urandom_range(0, 12))
                                        : OCT_W'($urandom_range(0, 31));
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        hi = OCT_W'($urandom_range(0, 31));
      end else if (roll == 1) begin
        hi = lo - 5'd1;
      end else begin
        acc = int'(lo) + int'($urandom_range(0, 8));
        hi  = (acc > 31) ? 5'd31 : OCT_W'(acc);
      end
      len = ($urandom_range(0, 4) != 0) ? CNT_W'($urandom_range(1, 8))
                                        : CNT_W'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 7) begin
        acc = $urandom_range(0, 2);
        for (int k = 0; k < MAX_SCALE_NOTES; k++) begin
          steps[8*k +: 8] = acc[7:0];
          acc += $urandom_range(1, 3);
        end
      end else begin
        steps = {$urandom, $urandom};
      end
      program_scale(root, lo, hi, len, steps);
      idling   = with_idling;
      idle_pct = with_idling ? 15 * $urandom_range(0, 3) : 0;
      for (int w = 0; w < words_per_phase; w++) begin
        roll = $urandom_range(0, 19);
        if (roll < 16) send_note(IN_W'($urandom_range(0, 255)));
        else send_note(IN_W'($urandom_range(0, 65535)));
      end
      finish_batch();
    end
  endtask

  // The receiver stalls in random bursts. A burst that is running when
  // idling is switched off runs to its end.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 99) < idle_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(1, BURST_MAX) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    snap_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_snaps.size() == 0) begin
        $display("%0t: result word with none expected: quantised_note %0d scale_empty %0b",
                 $time, quantised_note_o, scale_empty_o);
        mismatch_count++;
      end else begin
        want = pending_snaps.pop_front();
        if (quantised_note_o !== want.note) begin
          $display("%0t: quantised_note expected %0d, got %0d",
                   $time, want.note, quantised_note_o);
          mismatch_count++;
        end
        if (scale_empty_o !== want.empty) begin
          $display("%0t: scale_empty expected %0b, got %0b",
                   $time, want.empty, scale_empty_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("scale_note_quantiser verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_after_reset();
    test_major_scale();
    test_saturation_and_wrap();
    test_degenerate_lists();
    test_random_scales(14, 120, 1'b1);
    // The last part of the run has no idling on either side.
    test_random_scales(2, 130, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("scale_note_quantiser verification clean");
    end else begin
      $display("scale_note_quantiser verification failed");
    end
    $finish;
  end

endmodule
